// ----- rtl/mwpo_pkg.sv -----
// Shared constants, command codes and the sine table for the waveform oscillator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mwpo_pkg;

   // Field and state widths
   localparam int PHASE_BITS      = 32;
   localparam int SAMPLE_BITS     = 16;
   localparam int FREQ_BITS       = 24;
   localparam int CMD_BITS        = 3;
   localparam int SCALE_BITS      = 48;
   localparam int SCALE_HI_BITS   = SCALE_BITS - FREQ_BITS;
   localparam int PROD_BITS       = FREQ_BITS + SCALE_HI_BITS;
   localparam int SINE_DEPTH      = 1024;
   localparam int SINE_ADDR_BITS  = $clog2(SINE_DEPTH);

   // Configuration port
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_ADDR_BITS   = 4;
   localparam logic CSR_IDX_SCALE = 1'b0;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 48'd5864062015;

   // Sample levels
   localparam logic signed [SAMPLE_BITS-1:0] FULL_SCALE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIN_LEVEL  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0]        HALF_LEVEL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SINE     = 3'd0,
      CMD_SQUARE   = 3'd1,
      CMD_SAW_DOWN = 3'd2,
      CMD_SAW_UP   = 3'd3,
      CMD_TRIANGLE = 3'd4
   } cmd_type;

   typedef logic signed [SAMPLE_BITS-1:0] sine_table_type [SINE_DEPTH];

   // Build the sine table at elaboration: quarter-wave folding, Q30 Taylor
   // series in Horner form, then rounding to full scale.
   function automatic sine_table_type build_sine_table();
      sine_table_type  tbl;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned a;
      longint unsigned s;
      longint unsigned mag;
      longint unsigned one_q30;
      longint signed   val;
      one_q30 = 64'd1 << 30;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         u = (longint'(k) << 32) / SINE_DEPTH;
         q = (u >> 30) & 64'd3;
         r = u & (one_q30 - 64'd1);
         if (q[0]) begin
            r = one_q30 - r;
         end
         t  = (r * 64'd1686629713) >> 30;
         t2 = (t * t) >> 30;
         a  = one_q30;
         a  = one_q30 - ((t2 * a) >> 30) / 110;
         a  = one_q30 - ((t2 * a) >> 30) / 72;
         a  = one_q30 - ((t2 * a) >> 30) / 42;
         a  = one_q30 - ((t2 * a) >> 30) / 20;
         a  = one_q30 - ((t2 * a) >> 30) / 6;
         s   = (t * a) >> 30;
         mag = (s * longint'(FULL_SCALE) + (one_q30 >> 1)) >> 30;
         val = (q >= 64'd2) ? -longint'(mag) : longint'(mag);
         tbl[k] = SAMPLE_BITS'(val);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// ----- rtl/mwpo_wave.sv -----
// Waveform shaper: turns the current phase and a command into one sample.
// Depends on mwpo_pkg for widths, command codes and the sine table.
`default_nettype none

module mwpo_wave (
   input  wire logic [mwpo_pkg::PHASE_BITS-1:0]         phase,
   input  wire mwpo_pkg::cmd_type                       command,
   output logic signed [mwpo_pkg::SAMPLE_BITS-1:0]      sample
);
   import mwpo_pkg::*;

   logic [SAMPLE_BITS-1:0]        top_bits;
   logic signed [SAMPLE_BITS-1:0] saw_up;
   logic signed [SAMPLE_BITS-1:0] saw_down;
   logic signed [SAMPLE_BITS-1:0] triangle;
   logic signed [SAMPLE_BITS-1:0] square;
   logic signed [SAMPLE_BITS-1:0] sine;
   logic [SINE_ADDR_BITS-1:0]     sine_addr;

   assign top_bits  = phase[PHASE_BITS-1 -: SAMPLE_BITS];
   assign sine_addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];

   // Saws: offset the top phase bits by half scale; the downward saw
   // clips its single overshoot where the top phase bits are zero
   assign saw_up   = top_bits - HALF_LEVEL;
   assign saw_down = (top_bits == '0) ? FULL_SCALE : HALF_LEVEL - top_bits;

   // Triangle is the magnitude of the upward saw, clipped at full scale
   assign triangle = (saw_up == MIN_LEVEL) ? FULL_SCALE :
                     (saw_up[SAMPLE_BITS-1] ? -saw_up : saw_up);

   // Square stays high up to and including the half-cycle point
   assign square = (!phase[PHASE_BITS-1] || phase == {1'b1, {(PHASE_BITS-1){1'b0}}}) ?
                   FULL_SCALE : -FULL_SCALE;

   assign sine = SINE_TABLE[sine_addr];

   // Select the waveform; unknown commands give silence
   always_comb begin
      case (command)
         CMD_SINE:     sample = sine;
         CMD_SQUARE:   sample = square;
         CMD_SAW_DOWN: sample = saw_down;
         CMD_SAW_UP:   sample = saw_up;
         CMD_TRIANGLE: sample = triangle;
         default:      sample = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/multi_waveform_phase_oscillator.sv -----
// Multi-waveform phase oscillator: one result beat per accepted request beat. Each
// request carries a signed Q16.8 frequency and a waveform command; the result is
// the Q1.15 sample (sine, square, saws or unipolar triangle) at the phase reached
// before that request, after which the phase advances by
// (frequency * increment_scale) >> 24, wrapping in both directions. The block
// sustains one beat per clock unless the result side stalls; a request passes the
// input register, two increment stages and result register, the rate being set by
// the phase accumulate in the last stage. increment_scale (byte address 0 of the
// 64-bit register port) must be changed by the user only while idle, which the block does not enforce.
`default_nettype none

module multi_waveform_phase_oscillator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [mwpo_pkg::FREQ_BITS-1:0]   req_frequency,
   input  wire logic [mwpo_pkg::CMD_BITS-1:0]           req_command,
   // result channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [mwpo_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   // register port
   input  wire logic                                    psel,
   input  wire logic                                    penable,
   input  wire logic                                    pwrite,
   input  wire logic [mwpo_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  wire logic [mwpo_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [mwpo_pkg::CSR_DATA_BITS-1:0]           prdata,
   output logic                                         pready
);
   import mwpo_pkg::*;

   // Stage 1: input register (frequency magnitude and sign)
   logic                     v1_ff;
   logic [FREQ_BITS-1:0]     mag1_ff, mag1_in;
   logic                     neg1_ff;
   cmd_type                  cmd1_ff;
   // Stage 2: partial products
   logic                     v2_ff;
   logic [PHASE_BITS-1:0]    prod_hi_ff, prod_hi_in;
   logic [PROD_BITS-1:0]     prod_lo_ff, prod_lo_in;
   logic                     neg2_ff;
   cmd_type                  cmd2_ff;
   // Stage 3: signed phase increment
   logic                     v3_ff;
   logic [PHASE_BITS-1:0]    inc_ff, inc_in;
   cmd_type                  cmd3_ff;
   // Result register and state
   logic                     rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [SCALE_BITS-1:0]    scale_ff;

   logic [FREQ_BITS-1:0]     freq_bits;
   logic [PROD_BITS-1:0]     prod_hi_full;
   logic [PHASE_BITS-1:0]    inc_sum;
   logic                     round_up;
   logic                     scale_wr;
   logic                     out_free, free3, free2, free1;
   logic                     move3, move2, move1, accept;

   // Flow control: each stage moves when the one ahead is empty or moving
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move3     = v3_ff && out_free;
   assign free3     = !v3_ff || move3;
   assign move2     = v2_ff && free3;
   assign free2     = !v2_ff || move2;
   assign move1     = v1_ff && free2;
   assign free1     = !v1_ff || move1;
   assign req_stall = !free1;
   assign accept    = req_valid && free1;

   // Take the frequency magnitude at the input
   assign freq_bits = req_frequency;
   assign mag1_in   = req_frequency[FREQ_BITS-1] ? -freq_bits : freq_bits;

   // Split the scale product into two narrow multiplies
   assign prod_hi_full = mag1_ff * scale_ff[SCALE_BITS-1:FREQ_BITS];
   assign prod_hi_in   = prod_hi_full[PHASE_BITS-1:0];
   assign prod_lo_in   = mag1_ff * scale_ff[FREQ_BITS-1:0];

   // Combine partials; round the low part up for negative frequencies so the
   // negated increment floors toward minus infinity
   assign round_up = neg2_ff && (|prod_lo_ff[FREQ_BITS-1:0]);
   assign inc_sum  = prod_hi_ff + PHASE_BITS'(prod_lo_ff[PROD_BITS-1:FREQ_BITS])
                     + PHASE_BITS'(round_up);
   assign inc_in   = neg2_ff ? -inc_sum : inc_sum;

   // Accumulate phase; the sample uses the phase before this beat's step
   assign phase_in = phase_ff + inc_ff;

   mwpo_wave u_wave (
      .phase   (phase_ff),
      .command (cmd3_ff),
      .sample  (sample_in)
   );

   // Register port: single scale register, always ready
   assign pready   = 1'b1;
   assign scale_wr = psel && penable && pwrite && pready
                     && (paddr[CSR_ADDR_BITS-1] == CSR_IDX_SCALE);
   assign prdata   = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_SCALE) ?
                     CSR_DATA_BITS'(scale_ff) : '0;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         scale_ff     <= SCALE_RESET;
      end else begin
         if (free1) begin
            v1_ff <= req_valid;
         end
         if (free2) begin
            v2_ff <= v1_ff;
         end
         if (free3) begin
            v3_ff <= v2_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= v3_ff;
         end
         if (move3) begin
            phase_ff <= phase_in;
         end
         if (scale_wr) begin
            scale_ff <= pwdata[SCALE_BITS-1:0];
         end
      end
   end

   // Payload: load each stage as its beat advances
   always_ff @(posedge clock) begin
      if (accept) begin
         mag1_ff <= mag1_in;
         neg1_ff <= req_frequency[FREQ_BITS-1];
         cmd1_ff <= cmd_type'(req_command);
      end
      if (move1) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
         neg2_ff    <= neg1_ff;
         cmd2_ff    <= cmd1_ff;
      end
      if (move2) begin
         inc_ff  <= inc_in;
         cmd3_ff <= cmd2_ff;
      end
      if (move3) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

`ifndef ASSERT_OFF
   // Phase only moves when a beat passes into the result register
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !move3 |=> $stable(phase_ff))
      else $error("phase changed without a beat leaving the increment stage");

   // A beat leaving the increment stage always lands in the result register
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      move3 |=> rsp_valid_ff)
      else $error("result register empty after a beat moved into it");

   // An accepted request always occupies the input register
   a_input_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted request lost at the input register");

   // A scale write takes effect on the next cycle
   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      scale_wr |=> scale_ff == $past(pwdata[SCALE_BITS-1:0]))
      else $error("scale register did not take the written value");
`endif

endmodule

`default_nettype wire

// ----- tb/multi_waveform_phase_oscillator_tb.sv -----
// Self-checking testbench for the multi-waveform phase oscillator.
// Depends on mwpo_pkg (command codes and port widths) and on the oscillator RTL only.
`timescale 1ns / 100ps

module multi_waveform_phase_oscillator_tb;
   import mwpo_pkg::*;

   localparam int CLOCK_PERIOD    = 2;
   localparam int RESET_CYCLES    = 5;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int TAIL_CYCLES     = 12;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int NUM_DIRECTED    = 21;
   localparam int NUM_SCALE_SETS  = 7;

   // Unused command codes: the block answers them with silence
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO  = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_MID = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI  = 3'd7;

   localparam logic [CSR_ADDR_BITS-1:0] SCALE_ADDR = 4'h0;
   localparam logic [SCALE_BITS-1:0] DEFAULT_SCALE  = 48'd5864062015;
   localparam logic [SCALE_BITS-1:0] UNIT_SCALE     = 48'h0000_0100_0000;
   localparam logic [SCALE_BITS-1:0] BYTE_SCALE     = 48'h0001_0000_0000;
   localparam logic [SCALE_BITS-1:0] MAX_SCALE      = 48'hFFFF_FFFF_FFFF;

   localparam logic signed [SAMPLE_BITS-1:0] TOP_LEVEL = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] LOW_LEVEL = 16'sh8000;
   localparam logic signed [SAMPLE_BITS-1:0] SILENCE   = 16'sh0000;
   localparam logic [PHASE_BITS-1:0]         HALF_TURN = 32'h8000_0000;
   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct {
      logic signed [FREQ_BITS-1:0]   frequency;
      logic [CMD_BITS-1:0]           command;
      bit                            known;
      logic signed [SAMPLE_BITS-1:0] sample;
   } tone_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY} stall_pattern_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [FREQ_BITS-1:0]   req_frequency;
   logic [CMD_BITS-1:0]           req_command;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [CSR_ADDR_BITS-1:0]      paddr;
   logic [CSR_DATA_BITS-1:0]      pwdata;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   // Beat-side tags: a sample known by inspection travels with its request
   bit                            req_known;
   logic signed [SAMPLE_BITS-1:0] req_known_sample;

   logic signed [SAMPLE_BITS-1:0] samples_due [$];
   logic [PHASE_BITS-1:0]         model_phase;
   logic [SCALE_BITS-1:0]         model_scale;
   int                            fail_count = 0;
   int                            quiet_cycles = 0;
   bit                            hold_off_request = 1'b0;

   tone_row_type directed_rows [NUM_DIRECTED] = '{
      '{24'sh000000, CMD_SINE,         1'b1, SILENCE},
      '{24'sh000000, CMD_SQUARE,       1'b1, TOP_LEVEL},
      '{24'sh000000, CMD_SAW_DOWN,     1'b1, TOP_LEVEL},
      '{24'sh000000, CMD_SAW_UP,       1'b1, LOW_LEVEL},
      '{24'sh000000, CMD_TRIANGLE,     1'b1, TOP_LEVEL},
      '{24'sh000000, CMD_RESERVED_LO,  1'b1, SILENCE},
      '{24'sh000000, CMD_RESERVED_MID, 1'b1, SILENCE},
      '{24'sh7FFFFF, CMD_RESERVED_HI,  1'b1, SILENCE},
      '{24'sh800000, CMD_SINE,         1'b0, SILENCE},
      '{24'shFFFFFF, CMD_SQUARE,       1'b0, SILENCE},
      '{24'sh000001, CMD_SAW_UP,       1'b0, SILENCE},
      '{24'sh000100, CMD_TRIANGLE,     1'b0, SILENCE},
      '{24'sh01B800, CMD_SINE,         1'b0, SILENCE},
      '{24'sh01B800, CMD_SAW_DOWN,     1'b0, SILENCE},
      '{24'shFE4800, CMD_SINE,         1'b0, SILENCE},
      '{24'sh7FFFFF, CMD_SQUARE,       1'b0, SILENCE},
      '{24'sh800000, CMD_TRIANGLE,     1'b0, SILENCE},
      '{24'sh5DC000, CMD_SQUARE,       1'b0, SILENCE},
      '{24'sh5DC000, CMD_SQUARE,       1'b0, SILENCE},
      '{24'sh5DC000, CMD_SAW_UP,       1'b0, SILENCE},
      '{24'shC00000, CMD_SINE,         1'b0, SILENCE}
   };

   multi_waveform_phase_oscillator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_frequency (req_frequency),
      .req_command   (req_command),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Quarter-wave sine level for a 10-bit table index, Q30 Horner series
   function automatic logic signed [SAMPLE_BITS-1:0] sine_level(input logic [9:0] index);
      longint unsigned divisors [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      longint unsigned fold;
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned series;
      longint unsigned level;
      logic signed [SAMPLE_BITS-1:0] magnitude;
      fold = longint'(index[7:0]) << 22;
      if (index[8]) begin
         fold = Q30_ONE - fold;
      end
      angle    = (fold * HALF_PI_Q30) >> 30;
      angle_sq = (angle * angle) >> 30;
      series   = Q30_ONE;
      foreach (divisors[i]) begin
         series = Q30_ONE - ((angle_sq * series) >> 30) / divisors[i];
      end
      level     = ((((angle * series) >> 30) * 64'd32767) + (Q30_ONE >> 1)) >> 30;
      magnitude = level[SAMPLE_BITS-1:0];
      return index[9] ? -magnitude : magnitude;
   endfunction

   // Sample of the selected waveform at a given phase
   function automatic logic signed [SAMPLE_BITS-1:0] waveform_sample(
         input logic [PHASE_BITS-1:0] phase, input logic [CMD_BITS-1:0] command);
      logic signed [SAMPLE_BITS:0] centred;
      centred = $signed({1'b0, phase[31:16]}) - 17'sd32768;
      case (command)
         CMD_SINE: begin
            return sine_level(phase[31:22]);
         end
         CMD_SQUARE: begin
            return (phase <= HALF_TURN) ? TOP_LEVEL : -TOP_LEVEL;
         end
         CMD_SAW_DOWN, CMD_TRIANGLE: begin
            // both saturate where the magnitude would reach one half-scale
            if (centred == -17'sd32768) begin
               return TOP_LEVEL;
            end
            if (command == CMD_SAW_DOWN || centred < 0) begin
               return SAMPLE_BITS'(-centred);
            end
            return centred[SAMPLE_BITS-1:0];
         end
         CMD_SAW_UP: begin
            return centred[SAMPLE_BITS-1:0];
         end
         default: begin
            return SILENCE;
         end
      endcase
   endfunction

   // Phase step: frequency times scale over 2^24, rounded towards minus infinity
   function automatic logic [PHASE_BITS-1:0] phase_increment(
         input logic signed [FREQ_BITS-1:0] frequency, input logic [SCALE_BITS-1:0] scale);
      logic [FREQ_BITS-1:0] magnitude;
      longint unsigned      hz;
      longint unsigned      coarse;
      longint unsigned      fine;
      magnitude = frequency[FREQ_BITS-1] ? FREQ_BITS'(-frequency) : frequency;
      hz        = magnitude;
      coarse    = hz * longint'(scale[47:24]);
      fine      = hz * longint'(scale[23:0]);
      if (frequency[FREQ_BITS-1]) begin
         return PHASE_BITS'(-(coarse + ((fine + 64'hFF_FFFF) >> 24)));
      end
      return PHASE_BITS'(coarse + (fine >> 24));
   endfunction

   function automatic logic signed [FREQ_BITS-1:0] random_frequency();
      logic signed [FREQ_BITS-1:0] pick;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // audio band, either direction
            pick = FREQ_BITS'($urandom_range(0, 24000 * 256));
            if ($urandom_range(0, 1) == 1) begin
               pick = -pick;
            end
         end
         4, 5, 6: pick = FREQ_BITS'($urandom());
         7: begin
            case ($urandom_range(0, 3))
               0: pick = 24'sh7FFFFF;
               1: pick = 24'sh800000;
               2: pick = 24'sh000001;
               default: pick = 24'shFFFFFF;
            endcase
         end
         8: pick = '0;
         default: begin
            // small step, either direction
            pick = FREQ_BITS'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1) begin
               pick = -pick;
            end
         end
      endcase
      return pick;
   endfunction

   function automatic logic [CMD_BITS-1:0] random_command();
      if ($urandom_range(0, 15) < 14) begin
         return CMD_BITS'($urandom_range(CMD_SINE, CMD_TRIANGLE));
      end
      return CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
   endfunction

   // Score result beats and predict each accepted request beat
   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] due;
      if (reset) begin
         model_phase = '0;
         model_scale = DEFAULT_SCALE;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               $error("result beat with nothing outstanding: sample %0d", rsp_sample);
               fail_count++;
            end else begin
               due = samples_due.pop_front();
               if (rsp_sample !== due) begin
                  $error("sample mismatch: expected %0d, actual %0d", due, rsp_sample);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due = req_known ? req_known_sample : waveform_sample(model_phase, req_command);
            samples_due.push_back(due);
            model_phase = model_phase + phase_increment(req_frequency, model_scale);
         end
         if (psel && penable && pwrite && pready && paddr == SCALE_ADDR) begin
            model_scale = pwdata[SCALE_BITS-1:0];
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result-side stall: rotating patterns, plus one long hold-off on request
   initial begin
      int                tick;
      bit                hold_off_done;
      stall_pattern_type pattern;
      tick          = 0;
      hold_off_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            tick++;
            pattern = stall_pattern_type'((tick / 48) % 4);
            case (pattern)
               STALL_NONE:        rsp_stall <= 1'b0;
               STALL_LIGHT:       rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_EVERY_THIRD: rsp_stall <= (tick % 3 == 0);
               default:           rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // Offer one request beat and hold it until taken
   task automatic offer_beat(input logic signed [FREQ_BITS-1:0] frequency,
         input logic [CMD_BITS-1:0] command, input bit known,
         input logic signed [SAMPLE_BITS-1:0] sample);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_frequency    <= frequency;
      req_command      <= command;
      req_known        <= known;
      req_known_sample <= sample;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic go_quiet(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      go_quiet(1);
      while (samples_due.size() != 0) @(posedge clock);
   endtask

   // Register access: setup cycle, then access cycle until pready
   task automatic csr_access(input bit write, input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= SCALE_ADDR;
      pwdata  <= write ? data : '0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (!write && prdata[SCALE_BITS-1:0] !== data[SCALE_BITS-1:0]) begin
         $error("increment_scale readback: expected %0d, actual %0d",
                data[SCALE_BITS-1:0], prdata[SCALE_BITS-1:0]);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_scale(input logic [SCALE_BITS-1:0] scale);
      drain();
      csr_access(1'b1, {16'h0000, scale});
      csr_access(1'b0, {16'h0000, scale});
   endtask

   // Random beats in bursts; back to back when gaps are off
   task automatic random_tones(input int count, input bit gaps);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      repeat (count) begin
         offer_beat(random_frequency(), random_command(), 1'b0, SILENCE);
         if (gaps) begin
            burst_left--;
            if (burst_left == 0) begin
               go_quiet($urandom_range(1, 6));
               burst_left = $urandom_range(1, 12);
            end
         end
      end
      drain();
   endtask

   initial begin
      logic [SCALE_BITS-1:0] scale_sets [NUM_SCALE_SETS];
      logic [PHASE_BITS-1:0] distance;
      scale_sets = '{MAX_SCALE, 48'd1, 48'd0, 48'({$urandom(), $urandom()}),
                     DEFAULT_SCALE, 48'({$urandom_range(1, 255), $urandom()}), UNIT_SCALE};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_frequency    = '0;
      req_command      = CMD_SINE;
      req_known        = 1'b0;
      req_known_sample = SILENCE;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = SCALE_ADDR;
      pwdata           = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats at the reset scale, starting from phase zero
      foreach (directed_rows[i]) begin
         offer_beat(directed_rows[i].frequency, directed_rows[i].command,
                    directed_rows[i].known, directed_rows[i].sample);
      end
      drain();

      // Steer the phase onto exactly half a turn: clear the low byte, then jump
      set_scale(UNIT_SCALE);
      offer_beat(FREQ_BITS'(-int'(model_phase[7:0])), CMD_SQUARE, 1'b0, SILENCE);
      set_scale(BYTE_SCALE);
      distance = HALF_TURN - model_phase;
      offer_beat(distance[31:8], CMD_SAW_UP, 1'b0, SILENCE);
      offer_beat('0, CMD_SQUARE, 1'b0, SILENCE);
      offer_beat('0, CMD_SAW_UP, 1'b0, SILENCE);
      offer_beat('0, CMD_TRIANGLE, 1'b0, SILENCE);
      offer_beat('0, CMD_SAW_DOWN, 1'b0, SILENCE);
      offer_beat(24'sh000001, CMD_SINE, 1'b0, SILENCE);
      offer_beat(24'shFFFFFE, CMD_SQUARE, 1'b0, SILENCE);
      offer_beat('0, CMD_SQUARE, 1'b0, SILENCE);
      drain();

      // Random beats under a range of scales; the default one runs under back-pressure
      foreach (scale_sets[i]) begin
         set_scale(scale_sets[i]);
         if (scale_sets[i] == DEFAULT_SCALE) begin
            hold_off_request = 1'b1;
            random_tones(ITEMS_PER_PHASE, 1'b0);
         end else begin
            random_tones(ITEMS_PER_PHASE, 1'b1);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && samples_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
